FILE: rtl/mips_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the MIPS32 subset core.
// No dependencies.
package mips_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MEM,
    S_HALTRD,
    S_RDA,
    S_RDB,
    S_EXEC,
    S_SYS,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    MK_HOST,
    MK_FETCH,
    MK_DATA
  } mem_kind_e;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_STEP  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_WRITE   = 3'd1;
  localparam logic [2:0] ST_EXIT    = 3'd2;
  localparam logic [2:0] ST_BADINST = 3'd3;
  localparam logic [2:0] ST_BADSYS  = 3'd4;
  localparam logic [2:0] ST_RANGE   = 3'd5;
  localparam logic [2:0] ST_BUDGET  = 3'd6;

  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] CFG_ENTRY  = 2'd0;
  localparam logic [1:0] CFG_STACK  = 2'd1;
  localparam logic [1:0] CFG_BUDGET = 2'd2;

  localparam logic [31:0] SYS_WRITE    = 32'd4004;
  localparam logic [31:0] SYS_EXIT     = 32'd4001;
  localparam logic [31:0] STACK_RESET  = 32'h07ff_f000;
  localparam logic [31:0] BUDGET_RESET = 32'd200000000;

  localparam logic [4:0] REG_V0 = 5'd2;
  localparam logic [4:0] REG_A0 = 5'd4;
  localparam logic [4:0] REG_A1 = 5'd5;
  localparam logic [4:0] REG_A2 = 5'd6;
  localparam logic [4:0] REG_SP = 5'd29;
  localparam logic [4:0] REG_RA = 5'd31;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  localparam logic [4:0] RI_BLTZ = 5'd0;
  localparam logic [4:0] RI_BGEZ = 5'd1;

endpackage

FILE: rtl/mips_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the core's request and result items.
// No dependencies.
interface mips_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] address;
  logic [31:0] data;

  modport source (output valid, output action, output address, output data, input ready);
  modport sink   (input valid, input action, input address, input data, output ready);
endinterface

interface mips_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  exit_code;
  logic [31:0] read_data;
  logic [1:0]  write_channel;
  logic [31:0] write_address;
  logic [31:0] write_count;
  logic [31:0] program_counter;

  modport source (output valid, output status, output exit_code, output read_data,
                  output write_channel, output write_address, output write_count,
                  output program_counter, input ready);
  modport sink   (input valid, input status, input exit_code, input read_data,
                  input write_channel, input write_address, input write_count,
                  input program_counter, output ready);
endinterface

FILE: rtl/mips_ram.sv
`timescale 1ns / 1ps
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
module mips_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/mips32_subset_core.sv
`timescale 1ns / 1ps
// Top level of the MIPS32 integer subset core: sequencer, ALU, register file, byte memory.
// Depends on mips_pkg, mips_if (item interfaces) and mips_ram.
//
// Usage:
//  - cmd_i carries one request item (action, address, data); rsp_o returns exactly one
//    result item per request. Config registers (entry, stack, budget) sit on the APB port
//    at byte addresses 0, 4, 8; the user must write them only while idle (not enforced).
//  - One request at a time: cmd_i.ready is high only in the idle state. Every memory
//    access goes through the single byte-wide guest memory port, one byte per cycle,
//    and register reads go one per cycle through the register file RAM.
//  - A step fetches the instruction word, reads two operands and executes, then does a
//    load/store or 4 register reads for a syscall; a halted step skips all that and
//    reads only $a0, when the core has exited, before it answers.
//  - After reset the core sweeps guest memory to zero, one byte per cycle, with cmd_i.ready
//    low; config writes are taken meanwhile.
//  - The result sits in an output register; while the receiver stalls the next
//    request can still be accepted and worked, and its result waits in a staging
//    register until the output register frees up.
module mips32_subset_core
  import mips_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mips_item_if.sink            cmd_i,
  mips_result_if.source        rsp_o,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [CFG_AW-1:0]    paddr_i,
  input  logic [31:0]          pwdata_i,
  output logic [31:0]          prdata_o,
  output logic                 pready_o
);
  localparam int unsigned MAW = $clog2(MEM_BYTES);

  // Range check: a + n <= MEM_BYTES, done in 34 bits so nothing wraps.
  function automatic logic fits(input logic [31:0] a, input logic [31:0] n);
    logic [33:0] s;
    s = {2'b00, a} + {2'b00, n};
    return s <= 34'(MEM_BYTES);
  endfunction

  // Config registers
  logic [31:0] entry_q, stack_q, budget_q;
  logic        cfg_we;
  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q  <= '0;
      stack_q  <= STACK_RESET;
      budget_q <= BUDGET_RESET;
    end else if (cfg_we) begin
      case (paddr_i[3:2])
        CFG_ENTRY:  entry_q  <= pwdata_i;
        CFG_STACK:  stack_q  <= pwdata_i;
        CFG_BUDGET: budget_q <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[3:2])
      CFG_ENTRY:  prdata_o = entry_q;
      CFG_STACK:  prdata_o = stack_q;
      CFG_BUDGET: prdata_o = budget_q;
      default:    prdata_o = '0;
    endcase
  end

  // State
  state_e      state_q, state_d;
  mem_kind_e   kind_q, kind_d;
  logic        mwr_q, mwr_d;           // memory sweep writes (else reads)
  logic        mld_q, mld_d;           // data access is a load
  logic [31:0] base_q, base_d;
  logic [31:0] wbuf_q, wbuf_d;
  logic [2:0]  size_q, size_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] word_q, word_d;
  logic [31:0] instr_q, instr_d;
  logic [31:0] a_q, a_d, b_q, b_d;
  logic [31:0] fd_q, fd_d, wa_q, wa_d;
  logic [31:0] pc_q, pc_d;
  logic [31:0] exec_q, exec_d;
  logic [2:0]  halt_q, halt_d;
  logic [31:0] rfv_q, rfv_d;           // register file valid bits
  logic [4:0]  ridx_q;
  logic [MAW-1:0] clr_q, clr_d;

  // Result staging and output register
  logic [2:0]  r_st_q, r_st_d;
  logic [7:0]  r_exit_q, r_exit_d;
  logic [31:0] r_rd_q, r_rd_d;
  logic [1:0]  r_ch_q, r_ch_d;
  logic [31:0] r_wa_q, r_wa_d, r_wn_q, r_wn_d;
  logic        ov_q, ov_d;
  logic [2:0]  o_st_q;
  logic [7:0]  o_exit_q;
  logic [31:0] o_rd_q, o_wa_q, o_wn_q, o_pc_q;
  logic [1:0]  o_ch_q;
  logic        o_load;

  // Memories
  logic           m_we;
  logic [MAW-1:0] m_waddr, m_raddr;
  logic [7:0]     m_wdata, m_rdata;
  logic           rf_we;
  logic [4:0]     rf_waddr, rf_raddr;
  logic [31:0]    rf_wdata, rf_rdata, rf_val;

  mips_ram #(.Width(8), .Depth(MEM_BYTES)) u_mem (
    .clk_i(clk_i), .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  mips_ram #(.Width(32), .Depth(32)) u_rf (
    .clk_i(clk_i), .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rf_raddr), .rdata_o(rf_rdata)
  );

  // Never-written registers (and r0) read as zero.
  assign rf_val = rfv_q[ridx_q] ? rf_rdata : '0;

  // Decode fields
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] uimm;
  logic [31:0] simm, br_tgt, jmp_tgt, ea;
  assign op      = instr_q[31:26];
  assign rs      = instr_q[25:21];
  assign rt      = instr_q[20:16];
  assign rd      = instr_q[15:11];
  assign sh      = instr_q[10:6];
  assign fn      = instr_q[5:0];
  assign uimm    = instr_q[15:0];
  assign simm    = {{16{uimm[15]}}, uimm};
  assign br_tgt  = pc_q + {simm[29:0], 2'b00};
  assign jmp_tgt = {pc_q[31:28], instr_q[25:0], 2'b00};
  assign ea      = a_q + simm;

  // Execute unit: one ALU / branch evaluation per instruction.
  logic        ex_we, ex_bad, ex_sys, ex_ld, ex_st;
  logic [4:0]  ex_widx;
  logic [31:0] ex_wval, ex_pc;
  logic [2:0]  ex_size;

  always_comb begin
    ex_we   = 1'b0;
    ex_widx = rt;
    ex_wval = '0;
    ex_pc   = pc_q;
    ex_bad  = 1'b0;
    ex_sys  = 1'b0;
    ex_ld   = 1'b0;
    ex_st   = 1'b0;
    ex_size = 3'd4;
    case (op)
      OP_SPECIAL: begin
        ex_widx = rd;
        case (fn)
          FN_SLL:     begin ex_we = 1'b1; ex_wval = b_q << sh; end
          FN_SRL:     begin ex_we = 1'b1; ex_wval = b_q >> sh; end
          FN_SRA:     begin ex_we = 1'b1; ex_wval = 32'($signed(b_q) >>> sh); end
          FN_JR:      ex_pc = a_q;
          FN_SYSCALL: ex_sys = 1'b1;
          FN_ADDU:    begin ex_we = 1'b1; ex_wval = a_q + b_q; end
          FN_SUBU:    begin ex_we = 1'b1; ex_wval = a_q - b_q; end
          FN_AND:     begin ex_we = 1'b1; ex_wval = a_q & b_q; end
          FN_OR:      begin ex_we = 1'b1; ex_wval = a_q | b_q; end
          FN_XOR:     begin ex_we = 1'b1; ex_wval = a_q ^ b_q; end
          FN_NOR:     begin ex_we = 1'b1; ex_wval = ~(a_q | b_q); end
          FN_SLT: begin
            ex_we = 1'b1; ex_wval = {31'b0, $signed(a_q) < $signed(b_q)};
          end
          FN_SLTU:    begin ex_we = 1'b1; ex_wval = {31'b0, a_q < b_q}; end
          default:    ex_bad = 1'b1;
        endcase
      end
      OP_REGIMM: begin
        if (rt == RI_BLTZ) begin
          if (a_q[31]) ex_pc = br_tgt;
        end else if (rt == RI_BGEZ) begin
          if (!a_q[31]) ex_pc = br_tgt;
        end else begin
          ex_bad = 1'b1;
        end
      end
      OP_J:    ex_pc = jmp_tgt;
      OP_JAL:  begin ex_we = 1'b1; ex_widx = REG_RA; ex_wval = pc_q; ex_pc = jmp_tgt; end
      OP_BEQ:  if (a_q == b_q) ex_pc = br_tgt;
      OP_BNE:  if (a_q != b_q) ex_pc = br_tgt;
      OP_BLEZ: if (a_q == '0 || a_q[31]) ex_pc = br_tgt;
      OP_BGTZ: if (a_q != '0 && !a_q[31]) ex_pc = br_tgt;
      OP_ADDI, OP_ADDIU: begin ex_we = 1'b1; ex_wval = a_q + simm; end
      OP_SLTI:  begin ex_we = 1'b1; ex_wval = {31'b0, $signed(a_q) < $signed(simm)}; end
      OP_SLTIU: begin ex_we = 1'b1; ex_wval = {31'b0, a_q < simm}; end
      OP_ANDI:  begin ex_we = 1'b1; ex_wval = a_q & {16'b0, uimm}; end
      OP_ORI:   begin ex_we = 1'b1; ex_wval = a_q | {16'b0, uimm}; end
      OP_XORI:  begin ex_we = 1'b1; ex_wval = a_q ^ {16'b0, uimm}; end
      OP_LUI:   begin ex_we = 1'b1; ex_wval = {uimm, 16'b0}; end
      OP_LB, OP_LBU: begin ex_ld = 1'b1; ex_size = 3'd1; end
      OP_LHU:        begin ex_ld = 1'b1; ex_size = 3'd2; end
      OP_LW:         begin ex_ld = 1'b1; ex_size = 3'd4; end
      OP_SB:         begin ex_st = 1'b1; ex_size = 3'd1; end
      OP_SH:         begin ex_st = 1'b1; ex_size = 3'd2; end
      OP_SW:         begin ex_st = 1'b1; ex_size = 3'd4; end
      default: ex_bad = 1'b1;
    endcase
  end

  // Shared decisions used by both the sequencer and the datapath.
  logic        accept, halted, over_budget, pc_fits, ea_fits, host_fits, sys_fits;
  logic        mem_done, rsp_free;
  logic [31:0] maddr;
  logic [1:0]  byte_sel;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid & cmd_i.ready;
  assign halted      = (halt_q != ST_OK);
  assign over_budget = (exec_q >= budget_q);
  assign pc_fits     = fits(pc_q, 32'd4);
  assign ea_fits     = fits(ea, {29'b0, ex_size});
  assign host_fits   = fits(cmd_i.address, 32'd4);
  assign sys_fits    = fits(wa_q, rf_val);
  assign mem_done    = (cnt_q == size_q);
  assign maddr       = base_q + {29'b0, cnt_q};
  assign byte_sel    = 2'(cnt_q - 3'd1);
  assign rsp_free    = !ov_q || rsp_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == MAW'(MEM_BYTES - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (cmd_i.action)
            ACT_WRITE, ACT_READ: state_d = host_fits ? S_MEM : S_RESP;
            ACT_START:           state_d = S_RESP;
            default: begin
              if (halted)           state_d = (halt_q == ST_EXIT) ? S_HALTRD : S_RESP;
              else if (over_budget) state_d = S_RESP;
              else                  state_d = pc_fits ? S_MEM : S_RESP;
            end
          endcase
        end
      end
      S_MEM:    if (mem_done) state_d = (kind_q == MK_FETCH) ? S_RDA : S_RESP;
      S_HALTRD: state_d = S_RESP;
      S_RDA:    state_d = S_RDB;
      S_RDB:    state_d = S_EXEC;
      S_EXEC: begin
        if (ex_sys && !ex_bad)          state_d = S_SYS;
        else if ((ex_ld || ex_st) && ea_fits) state_d = S_MEM;
        else                            state_d = S_RESP;
      end
      S_SYS:  if (cnt_q == 3'd3) state_d = S_RESP;
      S_RESP: if (rsp_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    kind_d  = kind_q;   mwr_d  = mwr_q;   mld_d   = mld_q;
    base_d  = base_q;   wbuf_d = wbuf_q;  size_d  = size_q;
    cnt_d   = cnt_q;    word_d = word_q;  instr_d = instr_q;
    a_d     = a_q;      b_d    = b_q;     fd_d    = fd_q;   wa_d = wa_q;
    pc_d    = pc_q;     exec_d = exec_q;  halt_d  = halt_q;
    rfv_d   = rfv_q;    clr_d  = clr_q;
    r_st_d  = r_st_q;   r_exit_d = r_exit_q; r_rd_d = r_rd_q;
    r_ch_d  = r_ch_q;   r_wa_d = r_wa_q;  r_wn_d  = r_wn_q;
    m_we    = 1'b0;
    m_waddr = maddr[MAW-1:0];
    m_wdata = wbuf_q[8*cnt_q[1:0] +: 8];
    m_raddr = maddr[MAW-1:0];
    rf_we   = 1'b0;
    rf_waddr = rt;
    rf_wdata = '0;
    rf_raddr = rs;
    o_load  = 1'b0;

    case (state_q)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        m_wdata = '0;
        clr_d   = clr_q + MAW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          r_st_d = ST_OK; r_exit_d = '0; r_rd_d = '0;
          r_ch_d = '0;    r_wa_d   = '0; r_wn_d = '0;
          cnt_d  = '0;    word_d   = '0;
          case (cmd_i.action)
            ACT_WRITE, ACT_READ: begin
              if (!host_fits) r_st_d = ST_RANGE;
              kind_d = MK_HOST;
              mwr_d  = (cmd_i.action == ACT_WRITE);
              base_d = cmd_i.address;
              wbuf_d = cmd_i.data;
              size_d = 3'd4;
            end
            ACT_START: begin
              rfv_d    = '0;
              rfv_d[REG_SP] = 1'b1;
              rf_we    = 1'b1;
              rf_waddr = REG_SP;
              rf_wdata = stack_q;
              pc_d     = entry_q;
              exec_d   = '0;
              halt_d   = ST_OK;
            end
            default: begin
              if (halted) begin
                r_st_d   = halt_q;
                rf_raddr = REG_A0;
              end else if (over_budget) begin
                halt_d = ST_BUDGET;
                r_st_d = ST_BUDGET;
              end else begin
                exec_d = exec_q + 32'd1;
                if (!pc_fits) begin
                  halt_d = ST_RANGE;
                  r_st_d = ST_RANGE;
                end
                kind_d = MK_FETCH;
                mwr_d  = 1'b0;
                base_d = pc_q;
                size_d = 3'd4;
              end
            end
          endcase
        end
      end
      S_MEM: begin
        // Byte sweep: issue at cnt < size, read data lands in the next cycle.
        if (!mem_done) begin
          m_we  = mwr_q;
          cnt_d = cnt_q + 3'd1;
        end
        if (!mwr_q && cnt_q != '0) word_d[8*byte_sel +: 8] = m_rdata;
        if (mem_done) begin
          case (kind_q)
            MK_HOST:  if (!mwr_q) r_rd_d = word_d;
            MK_FETCH: begin
              instr_d  = word_d;
              pc_d     = pc_q + 32'd4;
              rf_raddr = word_d[25:21];
            end
            default: begin
              if (mld_q) begin
                rf_we    = (rt != '0);
                rf_waddr = rt;
                rf_wdata = (op == OP_LB) ? {{24{word_d[7]}}, word_d[7:0]} : word_d;
                if (rt != '0) rfv_d[rt] = 1'b1;
              end
            end
          endcase
        end
      end
      S_HALTRD: r_exit_d = rf_val[7:0];
      S_RDA: begin
        a_d      = rf_val;
        rf_raddr = rt;
      end
      S_RDB: b_d = rf_val;
      S_EXEC: begin
        cnt_d  = '0;
        word_d = '0;
        if (ex_bad) begin
          halt_d = ST_BADINST;
          r_st_d = ST_BADINST;
        end else if (ex_sys) begin
          rf_raddr = REG_V0;
        end else if (ex_ld || ex_st) begin
          if (!ea_fits) begin
            halt_d = ST_RANGE;
            r_st_d = ST_RANGE;
          end
          kind_d = MK_DATA;
          mwr_d  = ex_st;
          mld_d  = ex_ld;
          base_d = ea;
          wbuf_d = b_q;
          size_d = ex_size;
        end else begin
          pc_d = ex_pc;
          if (ex_we && ex_widx != '0) begin
            rf_we    = 1'b1;
            rf_waddr = ex_widx;
            rf_wdata = ex_wval;
            rfv_d[ex_widx] = 1'b1;
          end
        end
      end
      S_SYS: begin
        // Reads $v0, $a0, $a1, $a2 in turn; decides with $a2 on the bus.
        cnt_d = cnt_q + 3'd1;
        case (cnt_q)
          3'd0:    begin a_d  = rf_val; rf_raddr = REG_A1 - 5'd1; end
          3'd1:    begin fd_d = rf_val; rf_raddr = REG_A1; end
          3'd2:    begin wa_d = rf_val; rf_raddr = REG_A2; end
          default: begin
            if (a_q == SYS_WRITE) begin
              if (sys_fits) begin
                r_st_d = ST_WRITE;
                r_ch_d = (fd_q == 32'd1) ? 2'd1 : (fd_q == 32'd2) ? 2'd2 : 2'd0;
                r_wa_d = wa_q;
                r_wn_d = rf_val;
                rf_we    = 1'b1;
                rf_waddr = REG_V0;
                rf_wdata = rf_val;
                rfv_d[REG_V0] = 1'b1;
              end else begin
                halt_d = ST_RANGE;
                r_st_d = ST_RANGE;
              end
            end else if (a_q == SYS_EXIT) begin
              halt_d   = ST_EXIT;
              r_st_d   = ST_EXIT;
              r_exit_d = fd_q[7:0];
            end else begin
              halt_d = ST_BADSYS;
              r_st_d = ST_BADSYS;
            end
          end
        endcase
      end
      S_RESP: o_load = rsp_free;
      default: ;
    endcase

    ov_d = ov_q && !rsp_o.ready;
    if (o_load) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pc_q    <= '0;
      exec_q  <= '0;
      halt_q  <= ST_OK;
      rfv_q   <= '0;
      ov_q    <= 1'b0;
      kind_q  <= MK_HOST;
      mwr_q   <= 1'b0;
      mld_q   <= 1'b0;
      cnt_q   <= '0;
      size_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pc_q    <= pc_d;
      exec_q  <= exec_d;
      halt_q  <= halt_d;
      rfv_q   <= rfv_d;
      ov_q    <= ov_d;
      kind_q  <= kind_d;
      mwr_q   <= mwr_d;
      mld_q   <= mld_d;
      cnt_q   <= cnt_d;
      size_q  <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    wbuf_q   <= wbuf_d;
    word_q   <= word_d;
    instr_q  <= instr_d;
    a_q      <= a_d;
    b_q      <= b_d;
    fd_q     <= fd_d;
    wa_q     <= wa_d;
    ridx_q   <= rf_raddr;
    r_st_q   <= r_st_d;
    r_exit_q <= r_exit_d;
    r_rd_q   <= r_rd_d;
    r_ch_q   <= r_ch_d;
    r_wa_q   <= r_wa_d;
    r_wn_q   <= r_wn_d;
    if (o_load) begin
      o_st_q   <= r_st_q;
      o_exit_q <= r_exit_q;
      o_rd_q   <= r_rd_q;
      o_ch_q   <= r_ch_q;
      o_wa_q   <= r_wa_q;
      o_wn_q   <= r_wn_q;
      o_pc_q   <= pc_q;
    end
  end

  assign rsp_o.valid           = ov_q;
  assign rsp_o.status          = o_st_q;
  assign rsp_o.exit_code       = o_exit_q;
  assign rsp_o.read_data       = o_rd_q;
  assign rsp_o.write_channel   = o_ch_q;
  assign rsp_o.write_address   = o_wa_q;
  assign rsp_o.write_count     = o_wn_q;
  assign rsp_o.program_counter = o_pc_q;
endmodule

FILE: rtl/mips_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the MIPS32 subset core, bound to the top level.
// Depends on mips_pkg and mips32_subset_core.
module mips_chk
  import mips_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cmd_valid_i,
  input logic        cmd_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  rsp_status_i,
  input logic [1:0]  rsp_channel_i,
  input logic [31:0] rsp_count_i
);
  // One item in flight: the core is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("core ready right after accepting an item");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i <= ST_BUDGET)
    else $error("status code out of range");

  a_write_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_WRITE |-> rsp_channel_i == '0 && rsp_count_i == '0)
    else $error("write fields set without a write request");
endmodule

bind mips32_subset_core mips_chk u_mips_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_channel_i (rsp_o.write_channel),
  .rsp_count_i   (rsp_o.write_count)
);
